// ===== sv/dptp_pkg.sv =====
// ----------------------------------------------------------------------------
// dptp_pkg
// Shared types and codes for the delayed one-shot pulse port bank.
// ----------------------------------------------------------------------------
package dptp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TK_WR,
    S_TK_END,
    S_RQ_WR,
    S_RQ_ACK
  } state_t;

  localparam logic       FUNC_TICK = 1'b0;
  localparam logic       FUNC_TRIG = 1'b1;

  localparam logic       KIND_ACK = 1'b0;
  localparam logic       KIND_PIN = 1'b1;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;

  localparam logic [15:0] DEFAULT_PULSE_RESET = 16'd10;

endpackage

// ===== sv/delayed_pulse_trigger_ports_unit.sv =====
// ----------------------------------------------------------------------------
// delayed_pulse_trigger_ports_unit
// Bank of one-shot pulse ports with optional start delay, driven by ticks and
// trigger requests. Per-port state lives in one entry RAM.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-------------------------------------
//  input    | start / busy              | in_func, in_port_index,
//           |                           | in_pulse_length, in_start_delay
//  result   | out_strobe (one cycle)    | out_kind, out_status, out_event_port,
//           |                           | out_level, out_last
//  config   | cfg_valid / cfg_ready     | cfg_default_pulse_length
//
// A tick walks the entry RAM one port per cycle, bounded by the single RAM
// read port; busy stays high through S_TK_WR and S_TK_END after the transfer.
// A request to a valid port passes S_RQ_WR then S_RQ_ACK; an invalid one, S_RQ_ACK.
// Results are registered, out in the next cycle; the receiver cannot stall.
// Synchronous reset marks every entry as unwritten, which reads as idle.
// ----------------------------------------------------------------------------
module delayed_pulse_trigger_ports_unit #(
  parameter int NUM_PORTS = 8,
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [7:0]  in_port_index,
  input  logic [15:0] in_pulse_length,
  input  logic [15:0] in_start_delay,
  output logic        out_strobe,
  output logic        out_kind,
  output logic [1:0]  out_status,
  output logic [7:0]  out_event_port,
  output logic        out_level,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_default_pulse_length
);

  import dptp_pkg::*;

  localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int EW = 2 + 2 * TIME_BITS;
  localparam logic [PW-1:0] LAST_PORT = PW'(NUM_PORTS - 1);

  state_t                state_r, state_nxt;
  logic [PW-1:0]         cnt_r, cnt_nxt;
  logic [NUM_PORTS-1:0]  vld_r, vld_nxt;
  logic                  rd_vld_r;
  logic [15:0]           dflt_r;
  logic                  pend_vld_r, pend_vld_nxt;
  logic [PW-1:0]         pend_port_r, pend_port_nxt;
  logic                  pend_lvl_r, pend_lvl_nxt;
  logic [7:0]            rq_port_r, rq_port_nxt;
  logic [TIME_BITS-1:0]  rq_dur_r, rq_dur_nxt;
  logic [TIME_BITS-1:0]  rq_dly_r, rq_dly_nxt;
  logic                  rq_now_r, rq_now_nxt;
  logic [1:0]            stat_r, stat_nxt;

  logic                  strobe_r, strobe_nxt;
  logic                  kind_r, kind_nxt;
  logic [1:0]            ostat_r, ostat_nxt;
  logic [7:0]            oport_r, oport_nxt;
  logic                  lvl_r, lvl_nxt;
  logic                  last_r, last_nxt;

  logic                  ram_we;
  logic [PW-1:0]         ram_waddr, ram_raddr;
  logic [EW-1:0]         ram_wdata, ram_rdata, ent;
  logic [1:0]            ent_ph;
  logic [TIME_BITS-1:0]  ent_rem, ent_held;

  logic                  accept;
  logic [15:0]           len_sel;
  logic [TIME_BITS-1:0]  len_sat, dly_sat;
  logic                  port_bad;

  dptp_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_PORTS),
    .AW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign out_strobe     = strobe_r;
  assign out_kind       = kind_r;
  assign out_status     = ostat_r;
  assign out_event_port = oport_r;
  assign out_level      = lvl_r;
  assign out_last       = last_r;

  // An entry never written since reset reads as an idle port with zero counts.
  assign ent      = rd_vld_r ? ram_rdata : '0;
  assign ent_ph   = ent[EW-1 -: 2];
  assign ent_rem  = ent[2*TIME_BITS-1 -: TIME_BITS];
  assign ent_held = ent[TIME_BITS-1:0];

  assign len_sel  = (in_pulse_length == 16'd0) ? dflt_r : in_pulse_length;
  assign len_sat  = ((len_sel >> TIME_BITS) != 16'd0) ? '1 : TIME_BITS'(len_sel);
  assign dly_sat  = ((in_start_delay >> TIME_BITS) != 16'd0) ? '1 :
                    TIME_BITS'(in_start_delay);
  assign port_bad = ({1'b0, in_port_index} >= 9'(NUM_PORTS));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    vld_nxt       = vld_r;
    pend_vld_nxt  = pend_vld_r;
    pend_port_nxt = pend_port_r;
    pend_lvl_nxt  = pend_lvl_r;
    rq_port_nxt   = rq_port_r;
    rq_dur_nxt    = rq_dur_r;
    rq_dly_nxt    = rq_dly_r;
    rq_now_nxt    = rq_now_r;
    stat_nxt      = stat_r;
    strobe_nxt    = 1'b0;
    kind_nxt      = KIND_ACK;
    ostat_nxt     = ST_NONE;
    oport_nxt     = 8'd0;
    lvl_nxt       = 1'b0;
    last_nxt      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = ent;
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_TICK) begin
            cnt_nxt   = '0;
            state_nxt = S_TK_WR;
          end else begin
            rq_port_nxt = in_port_index;
            rq_dur_nxt  = len_sat;
            rq_dly_nxt  = dly_sat;
            rq_now_nxt  = (in_start_delay == 16'd0);
            ram_raddr   = in_port_index[PW-1:0];
            if (port_bad) begin
              stat_nxt  = ST_INVALID;
              state_nxt = S_RQ_ACK;
            end else begin
              state_nxt = S_RQ_WR;
            end
          end
        end
      end

      S_TK_WR: begin
        // Read the next port while updating this one.
        ram_raddr = (cnt_r == LAST_PORT) ? '0 : cnt_r + PW'(1);
        ram_waddr = cnt_r;
        if (ent_ph == PH_WAIT || ent_ph == PH_HIGH) begin
          ram_we = 1'b1;
          if (ent_rem > TIME_BITS'(1)) begin
            ram_wdata = {ent_ph, ent_rem - TIME_BITS'(1), ent_held};
          end else begin
            if (ent_ph == PH_WAIT) begin
              ram_wdata = {PH_HIGH, ent_held, ent_held};
            end else begin
              ram_wdata = {PH_IDLE, {TIME_BITS{1'b0}}, {TIME_BITS{1'b0}}};
            end
            // Each event is held back until the next one so the final one can carry last.
            if (pend_vld_r) begin
              strobe_nxt = 1'b1;
              kind_nxt   = KIND_PIN;
              oport_nxt  = 8'(pend_port_r);
              lvl_nxt    = pend_lvl_r;
            end
            pend_vld_nxt  = 1'b1;
            pend_port_nxt = cnt_r;
            pend_lvl_nxt  = (ent_ph == PH_WAIT);
          end
          vld_nxt[cnt_r] = 1'b1;
        end
        if (cnt_r == LAST_PORT) begin
          state_nxt = S_TK_END;
        end else begin
          cnt_nxt = cnt_r + PW'(1);
        end
      end

      S_TK_END: begin
        if (pend_vld_r) begin
          strobe_nxt = 1'b1;
          kind_nxt   = KIND_PIN;
          oport_nxt  = 8'(pend_port_r);
          lvl_nxt    = pend_lvl_r;
          last_nxt   = 1'b1;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end

      S_RQ_WR: begin
        ram_waddr = rq_port_r[PW-1:0];
        stat_nxt  = ST_NONE;
        if (rq_now_r) begin
          if (ent_ph == PH_HIGH) begin
            stat_nxt = ST_BUSY;
          end else begin
            ram_we     = 1'b1;
            ram_wdata  = {PH_HIGH, rq_dur_r, rq_dur_r};
            strobe_nxt = 1'b1;
            kind_nxt   = KIND_PIN;
            oport_nxt  = rq_port_r;
            lvl_nxt    = 1'b1;
          end
        end else if (ent_ph == PH_WAIT || ent_ph == PH_HIGH) begin
          stat_nxt = ST_BUSY;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {PH_WAIT, rq_dly_r, rq_dur_r};
        end
        if (ram_we) begin
          vld_nxt[rq_port_r[PW-1:0]] = 1'b1;
        end
        state_nxt = S_RQ_ACK;
      end

      S_RQ_ACK: begin
        strobe_nxt = 1'b1;
        kind_nxt   = KIND_ACK;
        ostat_nxt  = stat_r;
        oport_nxt  = rq_port_r;
        last_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      vld_r      <= '0;
      pend_vld_r <= 1'b0;
      strobe_r   <= 1'b0;
      dflt_r     <= DEFAULT_PULSE_RESET;
    end else begin
      state_r    <= state_nxt;
      vld_r      <= vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      strobe_r   <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        dflt_r <= cfg_default_pulse_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    rd_vld_r    <= vld_r[ram_raddr];
    pend_port_r <= pend_port_nxt;
    pend_lvl_r  <= pend_lvl_nxt;
    rq_port_r   <= rq_port_nxt;
    rq_dur_r    <= rq_dur_nxt;
    rq_dly_r    <= rq_dly_nxt;
    rq_now_r    <= rq_now_nxt;
    stat_r      <= stat_nxt;
    kind_r      <= kind_nxt;
    ostat_r     <= ostat_nxt;
    oport_r     <= oport_nxt;
    lvl_r       <= lvl_nxt;
    last_r      <= last_nxt;
  end

endmodule

// ===== sv/dptp_ram.sv =====
// ----------------------------------------------------------------------------
// dptp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dptp_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
